[sv/dea_pkg.sv]
`default_nettype none

package dea_pkg;

  // Frame geometry limits
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned RowW      = $clog2(MaxHeight);

  // Field widths
  localparam int unsigned DepthW    = 16;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned ThrW      = 12;
  localparam int unsigned ProdW     = DepthW + ThrW;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 13;
  localparam int unsigned CfgWidthW = 11;
  localparam int unsigned CfgHeightW = 13;

  // Five depth pairs of the 2x2 window, three possible results per pixel
  localparam int unsigned NumPairs  = 5;
  localparam int unsigned NumSlots  = 3;

  // Register values after reset
  localparam logic [CfgWidthW-1:0]  WidthReset  = CfgWidthW'(640);
  localparam logic [CfgHeightW-1:0] HeightReset = CfgHeightW'(480);
  localparam logic [ThrW-1:0]       ThrReset    = ThrW'(384);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_WIDTH     = 2'd0,
    CFG_IMAGE_HEIGHT    = 2'd1,
    CFG_ALIAS_THRESHOLD = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [DepthW-1:0] depth;
    logic [ChanW-1:0]  red;
    logic [ChanW-1:0]  green;
    logic [ChanW-1:0]  blue;
  } pixel_t;

  // Complete 2x2 window for one pixel
  typedef struct packed {
    pixel_t          ul;
    pixel_t          up;
    pixel_t          lf;
    pixel_t          cur;
    logic [ColW-1:0] x;
    logic [RowW-1:0] y;
  } win_t;

  // Prepared window: averaged pixel and per-pair operands of the edge test
  typedef struct packed {
    pixel_t                            ul;
    pixel_t                            up;
    pixel_t                            cur;
    pixel_t                            blend;
    logic [ColW-1:0]                   x;
    logic [RowW-1:0]                   y;
    logic [NumPairs-1:0][DepthW-1:0]   hi;
    logic [NumPairs-1:0][ProdW-1:0]    prod;
  } prep_t;

endpackage

`default_nettype wire

[sv/dea_line_buf.sv]
`default_nettype none

module dea_line_buf (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [dea_pkg::ColW-1:0]  addr_i,
  input  wire dea_pkg::pixel_t           wdata_i,
  output dea_pkg::pixel_t                rdata_o
);

  dea_pkg::pixel_t mem_q [dea_pkg::MaxWidth];
  dea_pkg::pixel_t rdata_q;

  // Read the old entry and replace it with the new pixel in the same cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      rdata_q        <= mem_q[addr_i];
      mem_q[addr_i]  <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/dea_edge_prep.sv]
`default_nettype none

module dea_edge_prep (
  input  wire logic                      clk_i,
  input  wire logic                      load_i,
  input  wire logic [dea_pkg::ThrW-1:0]  thr_i,
  input  wire dea_pkg::win_t             win_i,
  output dea_pkg::prep_t                 prep_o
);

  dea_pkg::prep_t prep_d;
  dea_pkg::prep_t prep_q;

  always_comb begin
    logic [dea_pkg::NumPairs-1:0][dea_pkg::DepthW-1:0] da;
    logic [dea_pkg::NumPairs-1:0][dea_pkg::DepthW-1:0] db;
    logic [dea_pkg::NumPairs-1:0][dea_pkg::DepthW-1:0] lo;
    logic [dea_pkg::DepthW+1:0] dsum;
    logic [dea_pkg::ChanW+1:0]  rsum;
    logic [dea_pkg::ChanW+1:0]  gsum;
    logic [dea_pkg::ChanW+1:0]  bsum;

    // Tested pairs; the right column pair is skipped
    da[0] = win_i.ul.depth;  db[0] = win_i.lf.depth;
    da[1] = win_i.ul.depth;  db[1] = win_i.cur.depth;
    da[2] = win_i.ul.depth;  db[2] = win_i.up.depth;
    da[3] = win_i.lf.depth;  db[3] = win_i.up.depth;
    da[4] = win_i.lf.depth;  db[4] = win_i.cur.depth;

    prep_d = '0;
    for (int i = 0; i < dea_pkg::NumPairs; i++) begin
      if (da[i] > db[i]) begin
        prep_d.hi[i] = da[i];
        lo[i]        = db[i];
      end else begin
        prep_d.hi[i] = db[i];
        lo[i]        = da[i];
      end
      prep_d.prod[i] = dea_pkg::ProdW'(thr_i) * dea_pkg::ProdW'(lo[i]);
    end

    // Truncated quarter of the four-pixel sum
    dsum = (dea_pkg::DepthW+2)'(win_i.ul.depth) + (dea_pkg::DepthW+2)'(win_i.up.depth)
         + (dea_pkg::DepthW+2)'(win_i.lf.depth) + (dea_pkg::DepthW+2)'(win_i.cur.depth);
    rsum = (dea_pkg::ChanW+2)'(win_i.ul.red) + (dea_pkg::ChanW+2)'(win_i.up.red)
         + (dea_pkg::ChanW+2)'(win_i.lf.red) + (dea_pkg::ChanW+2)'(win_i.cur.red);
    gsum = (dea_pkg::ChanW+2)'(win_i.ul.green) + (dea_pkg::ChanW+2)'(win_i.up.green)
         + (dea_pkg::ChanW+2)'(win_i.lf.green) + (dea_pkg::ChanW+2)'(win_i.cur.green);
    bsum = (dea_pkg::ChanW+2)'(win_i.ul.blue) + (dea_pkg::ChanW+2)'(win_i.up.blue)
         + (dea_pkg::ChanW+2)'(win_i.lf.blue) + (dea_pkg::ChanW+2)'(win_i.cur.blue);
    prep_d.blend.depth = dsum[dea_pkg::DepthW+1:2];
    prep_d.blend.red   = rsum[dea_pkg::ChanW+1:2];
    prep_d.blend.green = gsum[dea_pkg::ChanW+1:2];
    prep_d.blend.blue  = bsum[dea_pkg::ChanW+1:2];

    prep_d.ul  = win_i.ul;
    prep_d.up  = win_i.up;
    prep_d.cur = win_i.cur;
    prep_d.x   = win_i.x;
    prep_d.y   = win_i.y;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prep_q <= prep_d;
    end
  end

  assign prep_o = prep_q;

endmodule

`default_nettype wire

[sv/dea_result_seq.sv]
`default_nettype none

module dea_result_seq (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           load_i,
  input  wire logic [dea_pkg::NumSlots-1:0]   mask_i,
  input  wire dea_pkg::prep_t                 prep_i,
  output logic                                free_o,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [dea_pkg::ColW-1:0]            out_x_o,
  output logic [dea_pkg::RowW-1:0]            out_y_o,
  output logic [dea_pkg::DepthW-1:0]          out_depth_o,
  output logic [dea_pkg::ChanW-1:0]           out_red_o,
  output logic [dea_pkg::ChanW-1:0]           out_green_o,
  output logic [dea_pkg::ChanW-1:0]           out_blue_o,
  output logic                                was_blended_o,
  output logic                                last_of_run_o
);

  logic                          busy_q;
  logic [dea_pkg::NumSlots-1:0]  mask_q, mask_d, sel;
  logic                          out_ready, emit, edge_hit;
  logic                          out_valid_q;
  dea_pkg::pixel_t               pix_d, pix_q;
  logic [dea_pkg::ColW-1:0]      x_d, x_q;
  logic [dea_pkg::RowW-1:0]      y_d, y_q;
  logic                          blended_d, blended_q, last_q;

  always_comb begin
    edge_hit = 1'b0;
    for (int i = 0; i < dea_pkg::NumPairs; i++) begin
      if (dea_pkg::ProdW'({prep_i.hi[i], 8'h00}) > prep_i.prod[i]) begin
        edge_hit = 1'b1;
      end
    end
  end

  // Lowest pending result goes first
  assign sel[0] = mask_q[0];
  assign sel[1] = mask_q[1] & ~mask_q[0];
  assign sel[2] = mask_q[2] & ~mask_q[1] & ~mask_q[0];
  assign mask_d = mask_q & ~sel;

  assign out_ready = ~out_valid_q | ~out_stall_i;
  assign emit      = busy_q & (mask_q != '0) & out_ready;
  assign free_o    = ~busy_q | (mask_q == '0) | (emit & (mask_d == '0));

  always_comb begin
    if (sel[0]) begin
      x_d       = prep_i.x - dea_pkg::ColW'(1);
      y_d       = prep_i.y - dea_pkg::RowW'(1);
      pix_d     = edge_hit ? prep_i.blend : prep_i.ul;
      blended_d = edge_hit;
    end else if (sel[1]) begin
      x_d       = prep_i.x;
      y_d       = prep_i.y - dea_pkg::RowW'(1);
      pix_d     = prep_i.up;
      blended_d = 1'b0;
    end else begin
      x_d       = prep_i.x;
      y_d       = prep_i.y;
      pix_d     = prep_i.cur;
      blended_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        busy_q <= 1'b1;
        mask_q <= mask_i;
      end else if (free_o) begin
        busy_q <= 1'b0;
        mask_q <= '0;
      end else if (emit) begin
        mask_q <= mask_d;
      end
      if (out_ready) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      x_q       <= x_d;
      y_q       <= y_d;
      pix_q     <= pix_d;
      blended_q <= blended_d;
      last_q    <= (mask_d == '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_x_o       = x_q;
  assign out_y_o       = y_q;
  assign out_depth_o   = pix_q.depth;
  assign out_red_o     = pix_q.red;
  assign out_green_o   = pix_q.green;
  assign out_blue_o    = pix_q.blue;
  assign was_blended_o = blended_q;
  assign last_of_run_o = last_q;

endmodule

`default_nettype wire

[sv/depth_edge_antialias_unit.sv]
// A first result is valid after the window, prepared-window and output registers.
// Throughput: one pixel per cycle while no pixel makes more than one result and
// the output is not stalled; last-column and last-row pixels can make two or
// three and hold the input while their earlier results leave, one a cycle.
// Reset clears counters, upper-left and left window registers, handshake state
// and registers to their defaults; the line buffer is not cleared and needs none.
`default_nettype none

module depth_edge_antialias_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write channel
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [dea_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [dea_pkg::CfgDataW-1:0]      cfg_data_i,
  // pixel input channel
  input  wire logic                              pix_valid_i,
  output logic                                   pix_stall_o,
  input  wire logic [dea_pkg::DepthW-1:0]        pix_depth_i,
  input  wire logic [dea_pkg::ChanW-1:0]         pix_red_i,
  input  wire logic [dea_pkg::ChanW-1:0]         pix_green_i,
  input  wire logic [dea_pkg::ChanW-1:0]         pix_blue_i,
  // result channel
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [dea_pkg::ColW-1:0]               out_x_o,
  output logic [dea_pkg::RowW-1:0]               out_y_o,
  output logic [dea_pkg::DepthW-1:0]             out_depth_o,
  output logic [dea_pkg::ChanW-1:0]              out_red_o,
  output logic [dea_pkg::ChanW-1:0]              out_green_o,
  output logic [dea_pkg::ChanW-1:0]              out_blue_o,
  output logic                                   was_blended_o,
  output logic                                   last_of_run_o
);

  // Configuration registers
  logic [dea_pkg::CfgWidthW-1:0]  width_q;
  logic [dea_pkg::CfgHeightW-1:0] height_q;
  logic [dea_pkg::ThrW-1:0]       thr_q;

  // Raster position of the next pixel
  logic [dea_pkg::ColW-1:0] col_q, col_d;
  logic [dea_pkg::RowW-1:0] row_q, row_d;
  logic [dea_pkg::ColW-1:0] col_last;
  logic [dea_pkg::RowW-1:0] row_last;
  logic                     is_last_col, is_last_row;

  // Window stage: pixel just taken, plus upper-left and left neighbors
  logic                            win_valid_q;
  dea_pkg::pixel_t                 cur_q, up_pix, in_pix;
  dea_pkg::pixel_t                 ul_q, lf_q;
  logic [dea_pkg::ColW-1:0]        win_x_q;
  logic [dea_pkg::RowW-1:0]        win_y_q;
  logic [dea_pkg::NumSlots-1:0]    win_mask_q, win_mask_d;
  dea_pkg::win_t                   win;
  dea_pkg::prep_t                  prep;

  logic accept, advance, seq_free;

  assign cfg_ready_o = 1'b1;

  // Registers take writes at any time; the user writes them only when idle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= dea_pkg::WidthReset;
      height_q <= dea_pkg::HeightReset;
      thr_q    <= dea_pkg::ThrReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (dea_pkg::cfg_idx_e'(cfg_index_i))
        dea_pkg::CFG_IMAGE_WIDTH:     width_q  <= cfg_data_i[dea_pkg::CfgWidthW-1:0];
        dea_pkg::CFG_IMAGE_HEIGHT:    height_q <= cfg_data_i[dea_pkg::CfgHeightW-1:0];
        dea_pkg::CFG_ALIAS_THRESHOLD: thr_q    <= cfg_data_i[dea_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame size, then take the last column and row index.
  always_comb begin
    if (width_q < dea_pkg::CfgWidthW'(2)) begin
      col_last = dea_pkg::ColW'(1);
    end else if (width_q > dea_pkg::CfgWidthW'(dea_pkg::MaxWidth)) begin
      col_last = dea_pkg::ColW'(dea_pkg::MaxWidth - 1);
    end else begin
      col_last = dea_pkg::ColW'(width_q - dea_pkg::CfgWidthW'(1));
    end
    if (height_q < dea_pkg::CfgHeightW'(2)) begin
      row_last = dea_pkg::RowW'(1);
    end else if (height_q > dea_pkg::CfgHeightW'(dea_pkg::MaxHeight)) begin
      row_last = dea_pkg::RowW'(dea_pkg::MaxHeight - 1);
    end else begin
      row_last = dea_pkg::RowW'(height_q - dea_pkg::CfgHeightW'(1));
    end
  end

  // A counter at or past the last index counts as last, so a smaller size
  // written mid-frame still wraps cleanly.
  assign is_last_col = (col_q >= col_last);
  assign is_last_row = (row_q >= row_last);

  always_comb begin
    if (is_last_col) begin
      col_d = '0;
      row_d = is_last_row ? '0 : row_q + dea_pkg::RowW'(1);
    end else begin
      col_d = col_q + dea_pkg::ColW'(1);
      row_d = row_q;
    end
  end

  // Pending results of this pixel: the closed window's top-left, the
  // upper pixel at the right edge, and the pixel itself on the last row.
  assign win_mask_d[0] = (col_q != '0) && (row_q != '0);
  assign win_mask_d[1] = is_last_col && (row_q != '0);
  assign win_mask_d[2] = is_last_row;

  // Hold the input while the window stage is full and cannot move on.
  assign advance     = win_valid_q & seq_free;
  assign pix_stall_o = win_valid_q & ~seq_free;
  assign accept      = pix_valid_i & ~pix_stall_o;

  assign in_pix.depth = pix_depth_i;
  assign in_pix.red   = pix_red_i;
  assign in_pix.green = pix_green_i;
  assign in_pix.blue  = pix_blue_i;

  // Line buffer: read the pixel one row up and store the new one at the
  // same column in the transaction's cycle.
  dea_line_buf u_line_buf (
    .clk_i   (clk_i),
    .we_i    (accept),
    .addr_i  (col_q),
    .wdata_i (in_pix),
    .rdata_o (up_pix)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      win_valid_q <= 1'b0;
      ul_q        <= '0;
      lf_q        <= '0;
    end else begin
      if (accept) begin
        col_q       <= col_d;
        row_q       <= row_d;
        win_valid_q <= 1'b1;
      end else if (advance) begin
        win_valid_q <= 1'b0;
      end
      // Shift the window one column once this pixel moves on.
      if (advance) begin
        ul_q <= up_pix;
        lf_q <= cur_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q      <= in_pix;
      win_x_q    <= col_q;
      win_y_q    <= row_q;
      win_mask_q <= win_mask_d;
    end
  end

  assign win.ul  = ul_q;
  assign win.up  = up_pix;
  assign win.lf  = lf_q;
  assign win.cur = cur_q;
  assign win.x   = win_x_q;
  assign win.y   = win_y_q;

  // Products of the threshold with each pair's minimum, and the average.
  dea_edge_prep u_edge_prep (
    .clk_i  (clk_i),
    .load_i (advance),
    .thr_i  (thr_q),
    .win_i  (win),
    .prep_o (prep)
  );

  // Edge decision and one result per cycle into the output register while the output is not stalled.
  dea_result_seq u_result_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (advance),
    .mask_i        (win_mask_q),
    .prep_i        (prep),
    .free_o        (seq_free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .out_depth_o   (out_depth_o),
    .out_red_o     (out_red_o),
    .out_green_o   (out_green_o),
    .out_blue_o    (out_blue_o),
    .was_blended_o (was_blended_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

`default_nettype wire

[sim/depth_edge_antialias_unit_test.sv]
`timescale 1ns / 1ps

module depth_edge_antialias_unit_test;

  // Idle cycles after the last expected result before a register write or the
  // end of the run.
  localparam int unsigned DrainCycles = 12;
  // Index with no register behind it; a write there must change nothing.
  localparam logic [dea_pkg::CfgIdxW-1:0] CfgIdxSpare = 2'd3;

  // One result pixel as the block should present it
  typedef struct packed {
    bit [dea_pkg::ColW-1:0]   x;
    bit [dea_pkg::RowW-1:0]   y;
    bit [dea_pkg::DepthW-1:0] depth;
    bit [dea_pkg::ChanW-1:0]  red;
    bit [dea_pkg::ChanW-1:0]  green;
    bit [dea_pkg::ChanW-1:0]  blue;
    bit                       blended;
    bit                       run_last;
  } out_pixel_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [dea_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [dea_pkg::CfgDataW-1:0] cfg_data  = '0;

  logic                       pix_valid = 1'b0;
  logic                       pix_stall;
  logic [dea_pkg::DepthW-1:0] pix_depth = '0;
  logic [dea_pkg::ChanW-1:0]  pix_red   = '0;
  logic [dea_pkg::ChanW-1:0]  pix_green = '0;
  logic [dea_pkg::ChanW-1:0]  pix_blue  = '0;

  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [dea_pkg::ColW-1:0]   out_x;
  logic [dea_pkg::RowW-1:0]   out_y;
  logic [dea_pkg::DepthW-1:0] out_depth;
  logic [dea_pkg::ChanW-1:0]  out_red;
  logic [dea_pkg::ChanW-1:0]  out_green;
  logic [dea_pkg::ChanW-1:0]  out_blue;
  logic                       was_blended;
  logic                       last_of_run;

  // Idling of both sides, in percent of cycles
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Shadow of the registers and of the window state
  bit [dea_pkg::CfgWidthW-1:0]  width_cfg  = dea_pkg::WidthReset;
  bit [dea_pkg::CfgHeightW-1:0] height_cfg = dea_pkg::HeightReset;
  bit [dea_pkg::ThrW-1:0]       thr_cfg    = dea_pkg::ThrReset;
  dea_pkg::pixel_t              line_buf [dea_pkg::MaxWidth];
  bit                           line_written [dea_pkg::MaxWidth];
  dea_pkg::pixel_t              left_px       = '0;
  dea_pkg::pixel_t              upper_left_px = '0;
  int unsigned                  col_cnt = 0;
  int unsigned                  row_cnt = 0;
  int unsigned                  base_depth = 1000;

  out_pixel_t expected_out_pixels [$];

  int unsigned error_count     = 0;
  int unsigned pixels_sent     = 0;
  int unsigned results_checked = 0;
  int unsigned blended_count   = 0;
  int unsigned cfg_writes      = 0;

  depth_edge_antialias_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .pix_valid_i   (pix_valid),
    .pix_stall_o   (pix_stall),
    .pix_depth_i   (pix_depth),
    .pix_red_i     (pix_red),
    .pix_green_i   (pix_green),
    .pix_blue_i    (pix_blue),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_x_o       (out_x),
    .out_y_o       (out_y),
    .out_depth_o   (out_depth),
    .out_red_o     (out_red),
    .out_green_o   (out_green),
    .out_blue_o    (out_blue),
    .was_blended_o (was_blended),
    .last_of_run_o (last_of_run)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Window predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned eff_width(int unsigned w);
    return (w < 2) ? 2 : (w > dea_pkg::MaxWidth) ? dea_pkg::MaxWidth : w;
  endfunction

  // Edge when the larger depth exceeds threshold (Q4.8) times the smaller one;
  // a zero minimum is an edge for any nonzero maximum.
  function automatic bit is_depth_edge(bit [dea_pkg::DepthW-1:0] a,
                                       bit [dea_pkg::DepthW-1:0] b);
    bit [31:0] hi;
    bit [31:0] lo;
    hi = (a > b) ? a : b;
    lo = (a > b) ? b : a;
    return (hi << 8) > (lo * thr_cfg);
  endfunction

  // Truncated quarter of the four-pixel sum, channel by channel
  function automatic dea_pkg::pixel_t quarter_mean(dea_pkg::pixel_t a, dea_pkg::pixel_t b,
                                                   dea_pkg::pixel_t c, dea_pkg::pixel_t d);
    dea_pkg::pixel_t q;
    q.depth = dea_pkg::DepthW'((18'(a.depth) + 18'(b.depth) + 18'(c.depth)
                                + 18'(d.depth)) >> 2);
    q.red   = dea_pkg::ChanW'((10'(a.red) + 10'(b.red) + 10'(c.red) + 10'(d.red)) >> 2);
    q.green = dea_pkg::ChanW'((10'(a.green) + 10'(b.green) + 10'(c.green)
                               + 10'(d.green)) >> 2);
    q.blue  = dea_pkg::ChanW'((10'(a.blue) + 10'(b.blue) + 10'(c.blue)
                               + 10'(d.blue)) >> 2);
    return q;
  endfunction

  function automatic out_pixel_t make_out_pixel(int unsigned x, int unsigned y,
                                                dea_pkg::pixel_t p, bit blended);
    out_pixel_t r;
    r.x        = dea_pkg::ColW'(x);
    r.y        = dea_pkg::RowW'(y);
    r.depth    = p.depth;
    r.red      = p.red;
    r.green    = p.green;
    r.blue     = p.blue;
    r.blended  = blended;
    r.run_last = 1'b0;
    return r;
  endfunction

  // Advance the shadow by one accepted pixel and queue the 0 to 3 results it
  // closes: the window of (x-1, y-1), the pixel above at the last column, and
  // the pixel itself on the last row.
  function automatic void predict_window(dea_pkg::pixel_t cur);
    int unsigned     w;
    int unsigned     h;
    bit              last_col;
    bit              last_row;
    bit              found_edge;
    dea_pkg::pixel_t up;
    out_pixel_t      run [$];
    w = eff_width(width_cfg);
    h = (height_cfg < 2) ? 2 :
        (height_cfg > dea_pkg::MaxHeight) ? dea_pkg::MaxHeight : height_cfg;
    // A counter left beyond the new last index by a register change counts as last.
    last_col = col_cnt >= w - 1;
    last_row = row_cnt >= h - 1;
    up = line_buf[col_cnt];

    if (col_cnt >= 1 && row_cnt >= 1) begin
      // Top-right against lower-right is deliberately left out.
      found_edge = is_depth_edge(upper_left_px.depth, left_px.depth) ||
                   is_depth_edge(upper_left_px.depth, cur.depth) ||
                   is_depth_edge(upper_left_px.depth, up.depth) ||
                   is_depth_edge(left_px.depth, up.depth) ||
                   is_depth_edge(left_px.depth, cur.depth);
      if (found_edge) begin
        run.push_back(make_out_pixel(col_cnt - 1, row_cnt - 1,
                                     quarter_mean(upper_left_px, up, left_px, cur), 1'b1));
        blended_count++;
      end else begin
        run.push_back(make_out_pixel(col_cnt - 1, row_cnt - 1, upper_left_px, 1'b0));
      end
    end
    if (last_col && row_cnt >= 1) run.push_back(make_out_pixel(col_cnt, row_cnt - 1, up, 1'b0));
    if (last_row) run.push_back(make_out_pixel(col_cnt, row_cnt, cur, 1'b0));
    if (run.size() != 0) run[run.size() - 1].run_last = 1'b1;
    foreach (run[i]) expected_out_pixels.push_back(run[i]);

    upper_left_px         = up;
    line_buf[col_cnt]     = cur;
    line_written[col_cnt] = 1'b1;
    left_px               = cur;
    if (last_col) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : row_cnt + 1;
    end else begin
      col_cnt++;
    end
  endfunction

  // A width change is safe unless the rest of the current row would read line
  // buffer entries that were never written since reset.
  function automatic bit width_safe(int unsigned new_w);
    int unsigned stop;
    int unsigned i;
    if (row_cnt == 0) return 1'b1;
    stop = (new_w - 1 > col_cnt) ? new_w - 1 : col_cnt;
    for (i = col_cnt; i <= stop; i++) begin
      if (!line_written[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Depth mostly near a slowly moving surface depth, so that edges and flat
  // windows both show up; jumps to a new surface now and then.
  function automatic dea_pkg::pixel_t random_pixel();
    dea_pkg::pixel_t p;
    int unsigned     pick;
    int unsigned     span;
    int unsigned     d;
    if ($urandom_range(99) < 8) base_depth = $urandom_range(1, 65535);
    pick = $urandom_range(99);
    if (pick < 6) begin
      p.depth = '0;
    end else if (pick < 10) begin
      p.depth = '1;
    end else if (pick < 25) begin
      p.depth = dea_pkg::DepthW'($urandom);
    end else begin
      span = base_depth / 2;
      d = base_depth - span / 2 + $urandom_range(0, span);
      p.depth = (d > 65535) ? '1 : dea_pkg::DepthW'(d);
    end
    p.red   = dea_pkg::ChanW'($urandom);
    p.green = dea_pkg::ChanW'($urandom);
    p.blue  = dea_pkg::ChanW'($urandom);
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, bit [31:0] want, out_pixel_t at);
    if (got !== want)
      report_mismatch($sformatf("%s of pixel (%0d,%0d): got 0x%0h, want 0x%0h",
                                name, at.x, at.y, got, want));
  endtask

  // Compare each result transaction with the oldest expected pixel, then pick
  // the stall for the next cycle.
  always @(posedge clk) begin : result_check
    out_pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_out_pixels.size() == 0) begin
        report_mismatch($sformatf("result (%0d,%0d) with nothing expected", out_x, out_y));
      end else begin
        want = expected_out_pixels.pop_front();
        check_field("out_x", out_x, want.x, want);
        check_field("out_y", out_y, want.y, want);
        check_field("out_depth", out_depth, want.depth, want);
        check_field("out_red", out_red, want.red, want);
        check_field("out_green", out_green, want.green, want);
        check_field("out_blue", out_blue, want.blue, want);
        check_field("was_blended", was_blended, want.blended, want);
        check_field("last_of_run", last_of_run, want.run_last, want);
        results_checked++;
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Hold the payload until the block takes the transaction, then predict.
  task automatic send_pixel(dea_pkg::pixel_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix_depth <= p.depth;
    pix_red   <= p.red;
    pix_green <= p.green;
    pix_blue  <= p.blue;
    do @(posedge clk); while (pix_stall);
    predict_window(p);
    pixels_sent++;
  endtask

  // Drop valid and let every expected result arrive, plus DrainCycles idle cycles
  // for a pixel that makes no result.
  task automatic wait_drained();
    pix_valid <= 1'b0;
    while (expected_out_pixels.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_register(logic [dea_pkg::CfgIdxW-1:0] idx,
                                logic [dea_pkg::CfgDataW-1:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      dea_pkg::CFG_IMAGE_WIDTH:     width_cfg  = data[dea_pkg::CfgWidthW-1:0];
      dea_pkg::CFG_IMAGE_HEIGHT:    height_cfg = data[dea_pkg::CfgHeightW-1:0];
      dea_pkg::CFG_ALIAS_THRESHOLD: thr_cfg    = data[dea_pkg::ThrW-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic finish_frame();
    while (col_cnt != 0 || row_cnt != 0) send_pixel(random_pixel());
  endtask

  // Write all three registers; the bits above the width and threshold registers are random noise.
  // Finish the frame first where a wider row would read unwritten entries.
  task automatic configure_frame(int unsigned w, int unsigned h, int unsigned thr);
    if (!width_safe(eff_width(w))) finish_frame();
    write_register(dea_pkg::CFG_IMAGE_WIDTH, {2'($urandom), dea_pkg::CfgWidthW'(w)});
    write_register(dea_pkg::CFG_IMAGE_HEIGHT, dea_pkg::CfgHeightW'(h));
    write_register(dea_pkg::CFG_ALIAS_THRESHOLD, {1'($urandom), dea_pkg::ThrW'(thr)});
  endtask

  task automatic send_depth_list(int unsigned depths [$], bit full_chan);
    dea_pkg::pixel_t p;
    foreach (depths[i]) begin
      p = random_pixel();
      p.depth = dea_pkg::DepthW'(depths[i]);
      if (full_chan) begin
        p.red   = '1;
        p.green = '1;
        p.blue  = '1;
      end
      send_pixel(p);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Leave the threshold at its reset value (1.5): a ratio of exactly 1.5 is
  // no edge, a lone top-right/lower-right step is no edge, a 1.7 step is.
  task automatic test_default_threshold();
    write_register(dea_pkg::CFG_IMAGE_WIDTH, dea_pkg::CfgDataW'(4));
    write_register(dea_pkg::CFG_IMAGE_HEIGHT, dea_pkg::CfgDataW'(2));
    send_depth_list('{1000, 1500, 1250, 1250, 1000, 1500, 2125, 1250}, 1'b0);
  endtask

  // Zero and full-scale depths, full channels, threshold at both ends and
  // below one.
  task automatic test_depth_extremes();
    configure_frame(2, 2, 4095);
    send_depth_list('{0, 0, 0, 0}, 1'b0);          // both zero: flat
    send_depth_list('{0, 0, 0, 1}, 1'b0);          // zero minimum, max nonzero
    send_depth_list('{65535, 0, 0, 65535}, 1'b0);
    configure_frame(2, 2, 0);
    send_depth_list('{65535, 65535, 65535, 65535}, 1'b1);
    configure_frame(2, 2, 128);                    // threshold below one
    send_depth_list('{500, 500, 500, 500}, 1'b0);
  endtask

  // Register values outside the frame limits, a clamped wide row cut short by
  // a width change, and a very tall frame cut short by a height change.
  task automatic test_geometry_clamps();
    send_idle_pct  = 38;
    recv_stall_pct = 38;
    configure_frame(0, 0, 384);
    repeat (4) send_pixel(random_pixel());
    configure_frame(1, 1, 300);
    repeat (4) send_pixel(random_pixel());
    write_register(CfgIdxSpare, dea_pkg::CfgDataW'($urandom));
    repeat (4) send_pixel(random_pixel());
    configure_frame(2047, 2, 384);
    repeat (6) send_pixel(random_pixel());
    configure_frame(2, 8191, 512);                 // column counter now past the last column
    repeat (6) send_pixel(random_pixel());
    configure_frame(2, 2, 512);                    // row counter now past the last row
    finish_frame();
  endtask

  // Shrink the width past the column counter, the height past the row counter,
  // then grow the width again inside the frame.
  task automatic test_mid_frame_changes();
    send_idle_pct  = 0;
    recv_stall_pct = 46;
    configure_frame(8, 6, 400);
    repeat (21) send_pixel(random_pixel());
    configure_frame(3, 6, 300);
    repeat (7) send_pixel(random_pixel());
    configure_frame(3, 2, 500);
    repeat (5) send_pixel(random_pixel());
    configure_frame(8, 2, 450);
    repeat (6) send_pixel(random_pixel());
    finish_frame();
  endtask

  // Mostly whole frames of small random geometry; now and then a register
  // change lands inside a frame.
  task automatic test_random_stream(int unsigned idle, int unsigned stall, int unsigned budget);
    int unsigned start;
    int unsigned w;
    int unsigned h;
    int unsigned thr;
    int unsigned pick;
    int unsigned n;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    start = pixels_sent;
    while (pixels_sent - start < budget) begin
      if ($urandom_range(99) < 80) finish_frame();
      w = ($urandom_range(99) < 85) ? $urandom_range(2, 10) : $urandom_range(11, 48);
      h = ($urandom_range(99) < 90) ? $urandom_range(2, 7) : $urandom_range(8, 20);
      pick = $urandom_range(99);
      thr = (pick < 50) ? $urandom_range(256, 640) :
            (pick < 80) ? $urandom_range(256, 4095) : $urandom_range(0, 4095);
      configure_frame(w, h, thr);
      n = $urandom_range(1, (2 * w * h > 120) ? 120 : 2 * w * h);
      repeat (n) send_pixel(random_pixel());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : run_tests
    int unsigned wait_cycles;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_threshold();
    test_depth_extremes();
    test_geometry_clamps();
    test_mid_frame_changes();
    test_random_stream(0, 0, 60);
    test_random_stream(46, 0, 60);
    test_random_stream(0, 46, 60);
    test_random_stream(38, 38, 60);

    // Drain with a bound, then allow for the block's latency.
    pix_valid <= 1'b0;
    for (wait_cycles = 0; wait_cycles < 5000 && expected_out_pixels.size() != 0;
         wait_cycles++)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (expected_out_pixels.size() != 0)
      report_mismatch($sformatf("%0d expected pixels never arrived", expected_out_pixels.size()));

    $display("Sent %0d pixels, checked %0d results (%0d blended), %0d register writes.",
             pixels_sent, results_checked, blended_count, cfg_writes);
    $display("Covered clamped and mid-frame geometry and four sender/receiver idling mixes.");
    if (error_count == 0) begin
      $display("depth_edge_antialias_unit test passed");
    end else begin
      $display("depth_edge_antialias_unit test failed");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest correct run
  initial begin : run_limit
    #5_000_000;
    $display("depth_edge_antialias_unit test failed");
    $finish;
  end

endmodule

[sim.f]
sv/dea_pkg.sv
sv/dea_line_buf.sv
sv/dea_edge_prep.sv
sv/dea_result_seq.sv
sv/depth_edge_antialias_unit.sv
sim/depth_edge_antialias_unit_test.sv
